// ----- rtl/core/vnorm_pkg.sv -----
// Shared constants, types and control codes for the vector norm block.
`default_nettype none

package vnorm_pkg;

  // Fixed field widths and the default length bound
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned NORM_W      = 30;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned DEF_MAX_LEN = 4096;

  // Largest magnitude an element can have: the most negative value
  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << (ELEM_W - 1);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [NORM_W-1:0]        norm_t;
  typedef logic [MAG_W-1:0]         mag_t;

  // Root sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } vnorm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic load_root;  // load the root unit with the finished sum
    logic step_root;  // advance the root unit by one result bit
  } vnorm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_pending;  // final element of a vector sits in the square stage
    logic root_final;    // root unit is on its last iteration
  } vnorm_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/vnorm_if.sv -----
// Valid/ready channel interfaces for the element and result streams.
`default_nettype none

interface vnorm_in_if;
  import vnorm_pkg::*;

  logic  valid;
  logic  ready;
  elem_t element;
  logic  last_element;

  modport source (output valid, output element, output last_element, input ready);
  modport sink   (input valid, input element, input last_element, output ready);
endinterface

interface vnorm_out_if;
  import vnorm_pkg::*;

  logic  valid;
  logic  ready;
  norm_t euclid_norm;
  mag_t  max_abs;
  logic  too_long;

  modport source (output valid, output euclid_norm, output max_abs, output too_long,
                  input ready);
  modport sink   (input valid, input euclid_norm, input max_abs, input too_long,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/vnorm_ctrl.sv -----
// Controller: input flow control and sequencing of the square root unit.
`default_nettype none

module vnorm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  vnorm_pkg::vnorm_sts_t  sts,
  output vnorm_pkg::vnorm_cmd_t  cmd
);
  import vnorm_pkg::*;

  vnorm_state_t state_r, state_nxt;
  logic         root_busy;

  // A final element needs the root unit free by the time it leaves the square stage
  assign root_busy = sts.last_pending || (state_r != ST_IDLE);
  assign in_ready  = !(in_last && root_busy);
  assign out_valid = (state_r == ST_HOLD);

  assign cmd.accept    = in_valid && in_ready;
  assign cmd.load_root = (state_r == ST_IDLE) && sts.last_pending;
  assign cmd.step_root = (state_r == ST_RUN);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.last_pending) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.root_final) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vnorm_dp.sv -----
// Datapath: magnitude, square and accumulate, running maximum, iterative root.
`default_nettype none

module vnorm_dp #(
  parameter int unsigned MAX_LEN = vnorm_pkg::DEF_MAX_LEN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vnorm_pkg::elem_t       in_element,
  input  logic                   in_last,
  input  vnorm_pkg::vnorm_cmd_t  cmd,
  output vnorm_pkg::vnorm_sts_t  sts,
  output vnorm_pkg::norm_t       euclid_norm,
  output vnorm_pkg::mag_t        max_abs,
  output logic                   too_long
);
  import vnorm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned SQ_W   = 2 * ELEM_W - 1;
  localparam int unsigned SUM_W  = CNT_W + 2 * ELEM_W - 2;
  localparam int unsigned X_RAW  = SUM_W + 2 * FRAC_BITS;
  localparam int unsigned X_W    = X_RAW + (X_RAW % 2);
  localparam int unsigned ITER   = X_W / 2;
  localparam int unsigned ROOT_W = (ITER > NORM_W) ? ITER : NORM_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned IT_W   = $clog2(ITER);

  // Element stage
  logic [ELEM_W-1:0]   mag;
  logic [2*ELEM_W-1:0] prod;
  logic                include_elem;
  logic [ELEM_W-1:0]   max_sel;
  logic                ovf_sel;

  logic [CNT_W-1:0]    count_r;
  logic [ELEM_W-1:0]   max_r;
  logic                ovf_r;

  // Square stage
  logic                s1_last_r;
  logic                s1_add_r;
  logic [SQ_W-1:0]     sq_r;
  logic [ELEM_W-1:0]   s1_max_r;
  logic                s1_ovf_r;

  // Accumulator and result
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    total;
  logic [ELEM_W-1:0]   res_max_r;
  logic                res_ovf_r;

  // Root unit
  logic [X_W-1:0]      x_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [IT_W-1:0]     iter_r;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // Two's complement magnitude; the most negative value maps to 2^(ELEM_W-1)
  assign mag          = in_element[ELEM_W-1] ? (~in_element + ELEM_W'(1)) : in_element;
  assign prod         = mag * mag;
  assign include_elem = (count_r < CNT_W'(MAX_LEN));
  assign max_sel      = (mag > max_r) ? mag : max_r;
  assign ovf_sel      = ovf_r || !include_elem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      max_r     <= '0;
      ovf_r     <= 1'b0;
      s1_last_r <= 1'b0;
      s1_add_r  <= 1'b0;
    end else begin
      s1_last_r <= cmd.accept && in_last;
      s1_add_r  <= cmd.accept && include_elem;
      if (cmd.accept) begin
        if (in_last) begin
          // close the vector: start the next one from zero
          count_r <= '0;
          max_r   <= '0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= count_r + CNT_W'(include_elem);
          max_r   <= max_sel;
          ovf_r   <= ovf_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq_r     <= prod[SQ_W-1:0];
      s1_max_r <= max_sel;
      s1_ovf_r <= ovf_sel;
    end
  end

  assign total = sum_r + (s1_add_r ? SUM_W'(sq_r) : SUM_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (s1_last_r) begin
      sum_r <= '0;
    end else begin
      sum_r <= total;
    end
  end

  // Restoring square root, one result bit per cycle
  assign rem_sh = {rem_r[ROOT_W-1:0], x_r[X_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.load_root) begin
      x_r       <= X_W'(total) << (2 * FRAC_BITS);
      rem_r     <= '0;
      root_r    <= '0;
      iter_r    <= IT_W'(ITER - 1);
      res_max_r <= s1_max_r;
      res_ovf_r <= s1_ovf_r;
    end else if (cmd.step_root) begin
      x_r    <= x_r << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
      iter_r <= iter_r - IT_W'(1);
    end
  end

  assign sts.last_pending = s1_last_r;
  assign sts.root_final   = (iter_r == '0);

  assign euclid_norm = root_r[NORM_W-1:0];
  assign max_abs     = res_max_r;
  assign too_long    = res_ovf_r;

endmodule

`default_nettype wire

// ----- rtl/core/vector_l2_and_max_norm.sv -----
// Top level of the streaming vector norm unit (2-norm and infinity norm).
// After the final element transfers it passes the square stage, then the root unit
//   computes ITER result bits, ITER = (sum width + 2*FRAC_BITS)/2 rounded up.
// Throughput: one element per cycle; a final element waits while the bit-serial root
//   unit still works on the previous vector or its result is not yet taken.
// Reset: synchronous, active low; clears the accumulators, count and sequencer.
`default_nettype none

module vector_l2_and_max_norm #(
  parameter int unsigned MAX_LEN = vnorm_pkg::DEF_MAX_LEN
) (
  input  logic         clk,
  input  logic         rst_n,
  vnorm_in_if.sink     in_ch,
  vnorm_out_if.source  out_ch
);
  import vnorm_pkg::*;

  vnorm_cmd_t cmd;
  vnorm_sts_t sts;
  logic       in_ready;
  logic       out_valid;

  // Controller: gate final elements on the root unit, sequence the root, hold the result.
  // Non-final elements always transfer; they only feed the running sums.
  vnorm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_element),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: square each element, accumulate, track the maximum magnitude and
  // compute floor(sqrt(sum << 2*FRAC_BITS)) one bit per cycle. The result registers
  // hold the finished vector while the next vector keeps streaming in.
  vnorm_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_element  (in_ch.element),
    .in_last     (in_ch.last_element),
    .cmd         (cmd),
    .sts         (sts),
    .euclid_norm (out_ch.euclid_norm),
    .max_abs     (out_ch.max_abs),
    .too_long    (out_ch.too_long)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/core/vnorm_chk.sv -----
// Port-level checker for the vector norm unit and its bind to the top level.
`default_nettype none

module vnorm_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_last,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire vnorm_pkg::norm_t  euclid_norm,
  input wire vnorm_pkg::mag_t   max_abs,
  input wire logic              too_long
);
  import vnorm_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(euclid_norm) && $stable(max_abs)
      && $stable(too_long))
    else $error("result changed while stalled");

  // One result per root computation: none right after a transfer
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result valid right after transfer");

  // Infinity norm never exceeds the magnitude of the most negative representable element
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (max_abs <= MAG_LIMIT))
    else $error("max_abs out of range");

  // A final element is held off while a finished result waits
  a_last_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_valid && in_last |-> !in_ready)
    else $error("final element taken while result pending");

endmodule

bind vector_l2_and_max_norm vnorm_chk u_vnorm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_element),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .euclid_norm (out_ch.euclid_norm),
  .max_abs     (out_ch.max_abs),
  .too_long    (out_ch.too_long)
);

`default_nettype wire

// ----- bench/norm_checker.sv -----
`timescale 1ns / 1ps
// Checker for the vector norm unit: watches both channels, predicts results, compares them.
module norm_checker
  import vnorm_pkg::*;
#(
  parameter int unsigned VEC_LIMIT = DEF_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  vnorm_in_if         in_tap,
  vnorm_out_if        out_tap,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    norm_t euclid_norm;
    mag_t  max_abs;
    logic  too_long;
  } norm_result_t;

  norm_result_t expected_norms[$];

  // Running state of the vector being accumulated
  bit [63:0]   sq_total;
  mag_t        peak_mag;
  int unsigned elem_count;
  bit          overflowed;

  function automatic mag_t magnitude(elem_t e);
    return e[ELEM_W-1] ? mag_t'(-e) : mag_t'(e);
  endfunction

  // Bit-by-bit floor square root of the sum scaled by 2^(2*FRAC_BITS).
  // The sum stays below 2^43 at these widths, so the scaled value never overflows.
  function automatic norm_t scaled_root(bit [63:0] total);
    bit [63:0] scaled;
    bit [63:0] root;
    bit [63:0] guess;
    scaled = total << (2 * FRAC_BITS);
    root   = '0;
    for (int b = 31; b >= 0; b--) begin
      guess = root | (64'd1 << b);
      if (guess * guess <= scaled) root = guess;
    end
    return norm_t'(root);
  endfunction

  always @(posedge clk) begin
    norm_result_t want;
    norm_result_t got;
    mag_t         m;
    int unsigned  fails_now;
    fails_now = 0;
    if (!rst_n) begin
      sq_total   = '0;
      peak_mag   = '0;
      elem_count = 0;
      overflowed = 1'b0;
      expected_norms.delete();
    end else begin
      if (out_tap.valid && out_tap.ready) begin
        got = '{out_tap.euclid_norm, out_tap.max_abs, out_tap.too_long};
        if (expected_norms.size() == 0) begin
          $display("%0t: unexpected result norm=%0d max_abs=%0d too_long=%0b",
                   $time, got.euclid_norm, got.max_abs, got.too_long);
          fails_now++;
        end else begin
          want = expected_norms.pop_front();
          if (got.euclid_norm !== want.euclid_norm) begin
            $display("%0t: euclid_norm expected %0d, got %0d",
                     $time, want.euclid_norm, got.euclid_norm);
            fails_now++;
          end
          if (got.max_abs !== want.max_abs) begin
            $display("%0t: max_abs expected %0d, got %0d", $time, want.max_abs, got.max_abs);
            fails_now++;
          end
          if (got.too_long !== want.too_long) begin
            $display("%0t: too_long expected %0b, got %0b",
                     $time, want.too_long, got.too_long);
            fails_now++;
          end
        end
      end
      if (in_tap.valid && in_tap.ready) begin
        m = magnitude(in_tap.element);
        if (m > peak_mag) peak_mag = m;
        // Past the length bound the sum saturates, but the peak keeps tracking
        if (elem_count < VEC_LIMIT) begin
          sq_total   = sq_total + 64'(m) * 64'(m);
          elem_count = elem_count + 1;
        end else begin
          overflowed = 1'b1;
        end
        if (in_tap.last_element) begin
          expected_norms.push_back(norm_result_t'{scaled_root(sq_total), peak_mag,
                                                  overflowed});
          sq_total   = '0;
          peak_mag   = '0;
          elem_count = 0;
          overflowed = 1'b0;
        end
      end
    end
    mismatches  <= mismatches + fails_now;
    outstanding <= expected_norms.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the vector norm bench: clock, reset, element stimulus, result back-pressure, verdict.
module testbench;
  import vnorm_pkg::*;

  localparam int unsigned VEC_LIMIT       = DEF_MAX_LEN;
  localparam int unsigned ITEMS_PER_PHASE = 360;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Give the tail after the root computation a comfortable margin
  localparam int unsigned DRAIN_CYCLES    = 100;

  logic clk = 1'b0;
  logic rst_n;

  // Idle rates in percent, changed between phases by the stimulus
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Bump to ask the receiver for one long hold-off
  int unsigned hold_requests;

  int unsigned norm_mismatches;
  int unsigned norms_in_flight;

  vnorm_in_if  in_ch ();
  vnorm_out_if out_ch ();

  vector_l2_and_max_norm #(
    .MAX_LEN(VEC_LIMIT)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  norm_checker #(
    .VEC_LIMIT(VEC_LIMIT)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tap     (in_ch),
    .out_tap    (out_ch),
    .mismatches (norm_mismatches),
    .outstanding(norms_in_flight)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request so the block backs up
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one element, idling at random first; return at the edge of its transfer.
  task automatic push_element(input elem_t e, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      // Scramble the payload while idle; the block must ignore it
      in_ch.valid        <= 1'b0;
      in_ch.element      <= elem_t'($urandom);
      in_ch.last_element <= 1'($urandom);
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.element      <= e;
    in_ch.last_element <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Favor the extremes and small values, otherwise take any 16-bit pattern
  function automatic elem_t pick_element();
    case ($urandom_range(7))
      0:       return elem_t'(16'h8000);
      1:       return elem_t'(16'h7fff);
      2:       return elem_t'(int'($urandom_range(31)) - 16);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Stream whole vectors of random length until the element budget is spent
  task automatic random_vectors(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      for (int unsigned i = 0; i < len; i++) push_element(pick_element(), i == len - 1);
      sent = sent + len;
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.element      <= '0;
    in_ch.last_element <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 80;
    hold_requests = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Single-element vectors: zero, +-1 and the extremes, including the most negative value
    push_element(elem_t'(0), 1'b1);
    push_element(elem_t'(32767), 1'b1);
    push_element(elem_t'(-32768), 1'b1);
    push_element(elem_t'(-1), 1'b1);
    push_element(elem_t'(1), 1'b1);
    // 3-4-5 triangle: exact root
    push_element(elem_t'(3), 1'b0);
    push_element(elem_t'(-4), 1'b1);
    // Mixed extremes with a zero in the middle
    push_element(elem_t'(-32768), 1'b0);
    push_element(elem_t'(32767), 1'b0);
    push_element(elem_t'(0), 1'b0);
    push_element(elem_t'(1), 1'b1);
    // Irrational roots land on the fractional bits
    push_element(elem_t'(2), 1'b0);
    push_element(elem_t'(2), 1'b1);
    push_element(elem_t'(-32768), 1'b0);
    push_element(elem_t'(-32768), 1'b1);

    // Slow receiver
    random_vectors(ITEMS_PER_PHASE);

    // Slow sender
    send_idle_pct = 80;
    recv_idle_pct = 30;
    random_vectors(ITEMS_PER_PHASE);

    // Full rate, with one long receiver hold-off to back the block up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    random_vectors(ITEMS_PER_PHASE);
    in_ch.valid <= 1'b0;

    // Let the checker see the last transfer, then drain the outstanding results
    @(posedge clk);
    while (norms_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (norm_mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
